/* rtl/core/rfft_pkg.sv */
// rfft_pkg: shared types, codes and the quarter-wave sine table of the real fft
// depends on nothing; imported by every module of the block but rfft_ram

package rfft_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = 10;
    localparam int WORD_W     = 32;
    localparam int QUARTER    = MAX_POINTS / 4;
    localparam int LG_MIN     = 2;
    localparam int LG_MAX     = 10;

    localparam logic REG_INVERSE   = 1'b0;
    localparam logic REG_SIZE_LOG2 = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        JOB_SWAP,
        JOB_BFLY,
        JOB_SPLIT,
        JOB_DC
    } t_job;

    typedef enum logic [1:0] {
        PH_BITREV,
        PH_BFLY,
        PH_SPLIT,
        PH_DC
    } t_phase;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_PREP,
        DP_MUL_RP,
        DP_MUL_IQ,
        DP_MUL_RQ,
        DP_MUL_IP,
        DP_ACC,
        DP_RND,
        DP_OUT
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOST_RD,
        ST_ISSUE,
        ST_RD,
        ST_CAP,
        ST_PREP,
        ST_MUL_RP,
        ST_MUL_IQ,
        ST_MUL_RQ,
        ST_MUL_IP,
        ST_ACC,
        ST_RND,
        ST_OUT,
        ST_WR,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_dp_op              op;
        t_job                job;
        logic                inv;
        logic                mem_rd;
        logic                mem_wr;
        logic                host_sel;
        logic [ADDR_W-1:0]   addr;
        logic                cap_en;
        logic [1:0]          cap_slot;
        logic [1:0]          wr_slot;
        logic [ADDR_W-1:0]   tw;
        logic                clr_ovf;
    } t_dp_cmd;

    typedef struct packed {
        logic signed [WORD_W-1:0] rd_data;
        logic                     ovf;
    } t_dp_stat;

    typedef logic [30:0] t_sin_tab [0:QUARTER];

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q40  = PI_Q60 >> 20;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
    localparam logic [63:0] X_BIAS  = 64'(QUARTER) * 64'd1024;
    localparam logic [63:0] X_DIV   = 64'(QUARTER) * 64'd2048;
    localparam logic [63:0] TAY_D0  = 64'd210 << 30;
    localparam logic [63:0] TAY_D1  = 64'd156 << 30;
    localparam logic [63:0] TAY_D2  = 64'd110 << 30;
    localparam logic [63:0] TAY_D3  = 64'd72 << 30;
    localparam logic [63:0] TAY_D4  = 64'd42 << 30;
    localparam logic [63:0] TAY_D5  = 64'd20 << 30;
    localparam logic [63:0] TAY_D6  = 64'd6 << 30;

    // taylor series of sin up to x^15, nested form, rounded to unsigned q1.30
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] s;
        for (int k = 0; k <= QUARTER; k++) begin
            x  = (64'(k) * PI_Q40 + X_BIAS) / X_DIV;
            x2 = (x * x + HALF_Q30) >> 30;
            t  = ONE_Q30;
            q  = (x2 * t + (TAY_D0 >> 1)) / TAY_D0;
            t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
            q  = (x2 * t + (TAY_D1 >> 1)) / TAY_D1;
            t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
            q  = (x2 * t + (TAY_D2 >> 1)) / TAY_D2;
            t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
            q  = (x2 * t + (TAY_D3 >> 1)) / TAY_D3;
            t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
            q  = (x2 * t + (TAY_D4 >> 1)) / TAY_D4;
            t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
            q  = (x2 * t + (TAY_D5 >> 1)) / TAY_D5;
            t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
            q  = (x2 * t + (TAY_D6 >> 1)) / TAY_D6;
            t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
            s  = (x * t + HALF_Q30) >> 30;
            if (s > ONE_Q30) begin
                s = ONE_Q30;
            end
            tab[k] = 31'(s);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage

/* rtl/core/rfft_ram.sv */
// rfft_ram: generic single-write single-read memory with registered read data
// depends on nothing

module rfft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/rfft_dp.sv */
// rfft_dp: word memory, twiddle lookup, shared multiplier and butterfly arithmetic
// depends on rfft_pkg and rfft_ram

module rfft_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rfft_pkg::t_dp_cmd                i_cmd,
    input  logic signed [rfft_pkg::WORD_W-1:0] i_value,
    output rfft_pkg::t_dp_stat               o_stat
);
    import rfft_pkg::*;

    logic signed [WORD_W-1:0] r_d [0:3];
    logic signed [WORD_W-1:0] r_res [0:3];
    logic signed [31:0]       r_wr;
    logic signed [31:0]       r_wi;
    logic signed [33:0]       r_p;
    logic signed [33:0]       r_q;
    logic signed [65:0]       r_prod;
    logic signed [65:0]       r_acc;
    logic signed [66:0]       r_uf;
    logic signed [66:0]       r_vf;
    logic signed [36:0]       r_u;
    logic signed [36:0]       r_v;
    logic                     r_ovf;

    logic [WORD_W-1:0]        rdata;
    logic [WORD_W-1:0]        wdata;
    logic signed [31:0]       tw_re;
    logic signed [31:0]       tw_im;
    logic signed [33:0]       s3;
    logic signed [33:0]       s4;
    logic signed [33:0]       p_n;
    logic signed [33:0]       q_n;
    logic signed [31:0]       mul_a;
    logic signed [33:0]       mul_b;
    logic signed [65:0]       prod;
    logic signed [37:0]       o_w [0:3];
    logic signed [37:0]       e0;
    logic signed [37:0]       e1;
    logic signed [37:0]       e2;
    logic signed [37:0]       e3;
    logic signed [37:0]       eu;
    logic signed [37:0]       ev;
    logic signed [37:0]       s1;
    logic signed [37:0]       s2;
    logic signed [37:0]       sm;
    logic signed [37:0]       df;
    logic [32:0]              sat_r [0:3];

    function automatic logic signed [31:0] sin_full(logic [ADDR_W-1:0] j);
        logic [7:0]  r;
        logic [8:0]  ix;
        logic [31:0] m;
        r  = j[7:0];
        ix = j[8] ? 9'(QUARTER) - {1'b0, r} : {1'b0, r};
        m  = {1'b0, SIN_TAB[ix]};
        return j[9] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [32:0] sat32(logic signed [37:0] x);
        logic [32:0] y;
        if (x > 38'sh007FFFFFFF) begin
            y = {1'b1, 32'h7FFF_FFFF};
        end else if (x < -38'sh0080000000) begin
            y = {1'b1, 32'h8000_0000};
        end else begin
            y = {1'b0, x[31:0]};
        end
        return y;
    endfunction

    rfft_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.mem_wr),
        .i_waddr(i_cmd.addr),
        .i_wdata(wdata),
        .i_re   (i_cmd.mem_rd),
        .i_raddr(i_cmd.addr),
        .o_rdata(rdata)
    );

    assign wdata = i_cmd.host_sel ? i_value : r_res[i_cmd.wr_slot];

    // twiddle and multiplier operands
    always_comb begin
        tw_re = sin_full(ADDR_W'(i_cmd.tw + ADDR_W'(QUARTER)));
        tw_im = i_cmd.inv ? -sin_full(i_cmd.tw) : sin_full(i_cmd.tw);
        s3    = 34'(r_d[1]) + 34'(r_d[3]);
        s4    = 34'(r_d[0]) - 34'(r_d[2]);
        if (i_cmd.job == JOB_SPLIT) begin
            p_n = i_cmd.inv ? -s3 : s3;
            q_n = i_cmd.inv ? s4 : -s4;
        end else begin
            p_n = 34'(r_d[0]);
            q_n = 34'(r_d[1]);
        end
        mul_a = (i_cmd.op == DP_MUL_RP || i_cmd.op == DP_MUL_RQ) ? r_wr : r_wi;
        mul_b = (i_cmd.op == DP_MUL_RP || i_cmd.op == DP_MUL_IP) ? r_p : r_q;
        prod  = 66'(mul_a) * 66'(mul_b);
    end

    // output words of one job
    always_comb begin
        e0 = 38'(r_d[0]);
        e1 = 38'(r_d[1]);
        e2 = 38'(r_d[2]);
        e3 = 38'(r_d[3]);
        eu = 38'(r_u);
        ev = 38'(r_v);
        s1 = e0 + e2;
        s2 = e1 - e3;
        sm = e0 + e1;
        df = e0 - e1;
        unique case (i_cmd.job)
            JOB_SWAP: begin
                o_w[0] = e2;
                o_w[1] = e3;
                o_w[2] = e0;
                o_w[3] = e1;
            end
            JOB_BFLY: begin
                o_w[0] = e2 - eu;
                o_w[1] = e3 - ev;
                o_w[2] = e2 + eu;
                o_w[3] = e3 + ev;
            end
            JOB_SPLIT: begin
                o_w[0] = (s1 + eu + 38'sd1) >>> 1;
                o_w[1] = (s2 + ev + 38'sd1) >>> 1;
                o_w[2] = (s1 - eu + 38'sd1) >>> 1;
                o_w[3] = (ev - s2 + 38'sd1) >>> 1;
            end
            JOB_DC: begin
                o_w[0] = i_cmd.inv ? (sm + 38'sd1) >>> 1 : sm;
                o_w[1] = i_cmd.inv ? (df + 38'sd1) >>> 1 : df;
                o_w[2] = o_w[0];
                o_w[3] = o_w[1];
            end
            default: begin
                o_w[0] = e0;
                o_w[1] = e1;
                o_w[2] = e2;
                o_w[3] = e3;
            end
        endcase
        for (int s = 0; s < 4; s++) begin
            sat_r[s] = sat32(o_w[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            r_d[i_cmd.cap_slot] <= rdata;
        end
        unique case (i_cmd.op)
            DP_PREP: begin
                r_wr <= tw_re;
                r_wi <= tw_im;
                r_p  <= p_n;
                r_q  <= q_n;
            end
            DP_MUL_RP: begin
                r_prod <= prod;
            end
            DP_MUL_IQ: begin
                r_prod <= prod;
                r_acc  <= r_prod;
            end
            DP_MUL_RQ: begin
                r_prod <= prod;
                r_uf   <= 67'(r_acc) - 67'(r_prod);
            end
            DP_MUL_IP: begin
                r_prod <= prod;
                r_acc  <= r_prod;
            end
            DP_ACC: begin
                r_vf <= 67'(r_acc) + 67'(r_prod);
            end
            DP_RND: begin
                r_u <= 37'((r_uf + 67'sh2000_0000) >>> 30);
                r_v <= 37'((r_vf + 67'sh2000_0000) >>> 30);
            end
            DP_OUT: begin
                for (int s = 0; s < 4; s++) begin
                    r_res[s] <= sat_r[s][31:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else if (i_cmd.clr_ovf) begin
            r_ovf <= 1'b0;
        end else if (i_cmd.op == DP_OUT) begin
            r_ovf <= r_ovf | sat_r[0][32] | sat_r[1][32] | sat_r[2][32] | sat_r[3][32];
        end
    end

    assign o_stat.rd_data = rdata;
    assign o_stat.ovf     = r_ovf;

endmodule

/* rtl/core/rfft_ctrl.sv */
// rfft_ctrl: host handshake, config registers, result register and transform sequencer
// depends on rfft_pkg

module rfft_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_kind,
    input  logic [rfft_pkg::ADDR_W-1:0]      i_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [rfft_pkg::WORD_W-1:0] o_value_res,
    output logic                             o_is_status,
    output logic                             o_overflow,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [3:0]                       i_cfg_data,
    output rfft_pkg::t_dp_cmd                o_cmd,
    input  rfft_pkg::t_dp_stat               i_stat
);
    import rfft_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic                r_inv;
    logic [3:0]          r_size;
    logic [1:0]          r_ord;
    logic [9:0]          r_i;
    logic [8:0]          r_m;
    logic [3:0]          r_s;
    logic [8:0]          r_k;
    logic [1:0]          r_cnt;
    logic [ADDR_W-1:0]   r_addr [0:3];
    t_job                r_job;
    logic [ADDR_W-1:0]   r_tw;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_value;
    logic                r_out_status;
    logic                r_out_ovf;

    logic [9:0]          n_i;
    logic [8:0]          n_m;
    logic [3:0]          n_s;
    logic [8:0]          n_k;
    logic [3:0]          lg;
    logic [9:0]          nn;
    logic [10:0]         n_pts;
    logic [9:0]          len;
    logic [8:0]          rev;
    logic [8:0]          jr;
    logic [9:0]          jb;
    logic [9:0]          i_step;
    logic [8:0]          m_inc;
    logic [10:0]         c_pos;
    t_phase              phase;
    logic                over;
    logic                skip;
    t_job                job_n;
    logic [ADDR_W-1:0]   addr_n [0:3];
    logic [ADDR_W-1:0]   tw_n;
    logic                accept;
    logic                out_free;
    logic                out_load;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = ((r_state == ST_HOST_RD) || (r_state == ST_FINISH)) && out_free;
    assign phase    = t_phase'(r_ord ^ {r_inv, 1'b0});

    // loop bounds, addresses and advance of the current phase
    always_comb begin
        lg     = (r_size < 4'(LG_MIN)) ? 4'(LG_MIN) :
                 (r_size > 4'(LG_MAX)) ? 4'(LG_MAX) : r_size;
        nn     = 10'd1 << (lg - 4'd1);
        n_pts  = 11'd1 << lg;
        len    = 10'd1 << r_s;
        for (int b = 0; b < 9; b++) begin
            rev[b] = r_i[8 - b];
        end
        jr     = rev >> (4'd10 - lg);
        jb     = r_i + len;
        i_step = r_i + (len << 1);
        m_inc  = r_m + 9'd1;
        c_pos  = n_pts - {1'b0, r_k, 1'b0};
        n_i    = r_i;
        n_m    = r_m;
        n_s    = r_s;
        n_k    = r_k;
        over   = 1'b0;
        skip   = 1'b0;
        job_n  = JOB_DC;
        tw_n   = '0;
        for (int s = 0; s < 4; s++) begin
            addr_n[s] = '0;
        end
        unique case (phase)
            PH_BITREV: begin
                over      = (r_i == nn);
                skip      = (jr <= r_i[8:0]);
                job_n     = JOB_SWAP;
                addr_n[0] = {r_i[8:0], 1'b0};
                addr_n[1] = {r_i[8:0], 1'b1};
                addr_n[2] = {jr, 1'b0};
                addr_n[3] = {jr, 1'b1};
                n_i       = r_i + 10'd1;
            end
            PH_BFLY: begin
                over      = (r_s == lg - 4'd1);
                job_n     = JOB_BFLY;
                addr_n[0] = {jb[8:0], 1'b0};
                addr_n[1] = {jb[8:0], 1'b1};
                addr_n[2] = {r_i[8:0], 1'b0};
                addr_n[3] = {r_i[8:0], 1'b1};
                tw_n      = 10'(r_m) << (4'd9 - r_s);
                if (i_step >= nn) begin
                    if (10'(m_inc) == len) begin
                        n_s = r_s + 4'd1;
                        n_m = '0;
                        n_i = '0;
                    end else begin
                        n_m = m_inc;
                        n_i = 10'(m_inc);
                    end
                end else begin
                    n_i = i_step;
                end
            end
            PH_SPLIT: begin
                over      = ({2'b0, r_k} >= (n_pts >> 2));
                job_n     = JOB_SPLIT;
                addr_n[0] = {r_k[8:0], 1'b0};
                addr_n[1] = {r_k[8:0], 1'b1};
                addr_n[2] = c_pos[9:0];
                addr_n[3] = c_pos[9:0] | 10'd1;
                tw_n      = 10'(r_k) << (4'd10 - lg);
                n_k       = r_k + 9'd1;
            end
            PH_DC: begin
                over      = (r_i != 10'd0);
                job_n     = JOB_DC;
                addr_n[0] = 10'd0;
                addr_n[1] = 10'd1;
                addr_n[2] = 10'd0;
                addr_n[3] = 10'd1;
                n_i       = 10'd1;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_kind'(i_kind))
                        KIND_RUN:  n_state = ST_ISSUE;
                        KIND_READ: n_state = ST_HOST_RD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_HOST_RD: if (out_free) n_state = ST_IDLE;
            ST_ISSUE: begin
                if (over) begin
                    n_state = (r_ord == 2'd3) ? ST_FINISH : ST_ISSUE;
                end else if (skip && phase == PH_BITREV) begin
                    n_state = ST_ISSUE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_RD: if (r_cnt == 2'd3) n_state = ST_CAP;
            ST_CAP: begin
                n_state = (r_job == JOB_SWAP || r_job == JOB_DC) ? ST_OUT : ST_PREP;
            end
            ST_PREP:   n_state = ST_MUL_RP;
            ST_MUL_RP: n_state = ST_MUL_IQ;
            ST_MUL_IQ: n_state = ST_MUL_RQ;
            ST_MUL_RQ: n_state = ST_MUL_IP;
            ST_MUL_IP: n_state = ST_ACC;
            ST_ACC:    n_state = ST_RND;
            ST_RND:    n_state = ST_OUT;
            ST_OUT:    n_state = ST_WR;
            ST_WR:     if (r_cnt == 2'd3) n_state = ST_ISSUE;
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = DP_NOP;
        o_cmd.job      = r_job;
        o_cmd.inv      = r_inv;
        o_cmd.tw       = r_tw;
        o_cmd.addr     = r_addr[r_cnt];
        o_cmd.cap_slot = 2'(r_cnt - 2'd1);
        o_cmd.wr_slot  = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.host_sel = 1'b1;
                o_cmd.addr     = i_index;
                o_cmd.mem_wr   = accept && (t_kind'(i_kind) == KIND_LOAD);
                o_cmd.mem_rd   = accept && (t_kind'(i_kind) == KIND_READ);
                o_cmd.clr_ovf  = accept && (t_kind'(i_kind) == KIND_RUN);
            end
            ST_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.cap_en = (r_cnt != 2'd0);
            end
            ST_CAP: begin
                o_cmd.cap_en   = 1'b1;
                o_cmd.cap_slot = 2'd3;
            end
            ST_PREP:   o_cmd.op = DP_PREP;
            ST_MUL_RP: o_cmd.op = DP_MUL_RP;
            ST_MUL_IQ: o_cmd.op = DP_MUL_IQ;
            ST_MUL_RQ: o_cmd.op = DP_MUL_RQ;
            ST_MUL_IP: o_cmd.op = DP_MUL_IP;
            ST_ACC:    o_cmd.op = DP_ACC;
            ST_RND:    o_cmd.op = DP_RND;
            ST_OUT:    o_cmd.op = DP_OUT;
            ST_WR:     o_cmd.mem_wr = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inv       <= 1'b0;
            r_size      <= 4'(LG_MAX);
            r_out_valid <= 1'b0;
            r_ord       <= '0;
            r_cnt       <= '0;
            r_i         <= '0;
            r_m         <= '0;
            r_s         <= '0;
            r_k         <= 9'd1;
            r_job       <= JOB_DC;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_INVERSE:   r_inv  <= i_cfg_data[0];
                    REG_SIZE_LOG2: r_size <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept && t_kind'(i_kind) == KIND_RUN) begin
                r_ord <= '0;
                r_i   <= '0;
                r_m   <= '0;
                r_s   <= '0;
                r_k   <= 9'd1;
            end
            if (r_state == ST_ISSUE) begin
                if (over) begin
                    if (r_ord != 2'd3) begin
                        r_ord <= r_ord + 2'd1;
                        r_i   <= '0;
                        r_m   <= '0;
                        r_s   <= '0;
                        r_k   <= 9'd1;
                    end
                end else if (skip && phase == PH_BITREV) begin
                    r_i <= n_i;
                end else begin
                    r_job <= job_n;
                    r_cnt <= '0;
                end
            end
            if (r_state == ST_RD || r_state == ST_WR) begin
                r_cnt <= r_cnt + 2'd1;
            end
            if (r_state == ST_WR && r_cnt == 2'd3) begin
                r_i <= n_i;
                r_m <= n_m;
                r_s <= n_s;
                r_k <= n_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ISSUE && !over) begin
            for (int s = 0; s < 4; s++) begin
                r_addr[s] <= addr_n[s];
            end
            r_tw <= tw_n;
        end
        if (out_load) begin
            r_out_value  <= (r_state == ST_HOST_RD) ? i_stat.rd_data : '0;
            r_out_status <= (r_state == ST_FINISH);
            r_out_ovf    <= i_stat.ovf;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_is_status = r_out_status;
    assign o_overflow  = r_out_ovf;

endmodule

/* rtl/core/real_input_fft_top.sv */
// real_input_fft_top: in-place fixed-point real fft over a 1024-word store
// depends on rfft_pkg, rfft_ctrl, rfft_dp (which holds rfft_ram)
//
//  channel | handshake               | payload
//  input   | i_in_valid / o_in_stall | i_kind, i_index, i_value
//  output  | o_out_valid/ i_out_stall| o_value_res, o_is_status, o_overflow
//  config  | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// a load is written from the idle state; a read passes through a host-read state that waits out any output stall
// a transform runs one job at a time: four word reads; for butterfly and split pairs
// a prep, four products on the one shared 32x34 multiplier, accumulate and round; then
// the output step and four writes, over the single read and write ports of the word memory
// no clearing pass after reset; the store holds garbage until loaded
// the result register lets a new word be taken while a result waits

module real_input_fft_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_kind,
    input  logic [rfft_pkg::ADDR_W-1:0]      i_index,
    input  logic signed [rfft_pkg::WORD_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [rfft_pkg::WORD_W-1:0] o_value_res,
    output logic                             o_is_status,
    output logic                             o_overflow,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [3:0]                       i_cfg_data
);
    import rfft_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rfft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_index    (i_index),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_value_res(o_value_res),
        .o_is_status(o_is_status),
        .o_overflow (o_overflow),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    rfft_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (dp_cmd),
        .i_value(i_value),
        .o_stat (dp_stat)
    );

endmodule

/* bench/testbench.sv */
// testbench: checks real_input_fft_top against a fixed-point real fft predictor
// depends on rfft_pkg and the rtl of real_input_fft_top; self-contained otherwise

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rfft_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct {
        logic signed [31:0] value;
        logic               is_status;
        logic               ovf;
    } t_word_result;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic [1:0]          kind = KIND_LOAD;
    logic [ADDR_W-1:0]   index = '0;
    logic signed [31:0]  value = '0;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_index = REG_INVERSE;
    logic [3:0]          cfg_data = '0;
    logic                in_stall, out_valid, is_status, ovf_out, cfg_ready;
    logic signed [31:0]  value_res;

    real_input_fft_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_index(index), .i_value(value),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_value_res(value_res), .o_is_status(is_status), .o_overflow(ovf_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // fft predictor state
    int             sine_q30 [0:QUARTER];
    int             mem_words [0:MAX_POINTS-1];
    bit             written [0:MAX_POINTS-1];
    bit             sat_seen;
    bit             cur_inv;
    int             cur_lg;
    t_word_result   pending_words [$];
    int             mismatches;
    int             failures;
    bit             no_idle;
    int             hold_cycles;

    function automatic void build_sines();
        longint unsigned dv [7] = '{210, 156, 110, 72, 42, 20, 6};
        longint unsigned pi40, x, x2, t, q, s, den;
        pi40 = 64'h3243F6A8885A308D >> 20;
        for (int k = 0; k <= QUARTER; k++) begin
            x  = (longint'(k) * pi40 + QUARTER * 1024) / (QUARTER * 2048);
            x2 = (x * x + (64'd1 << 29)) >> 30;
            t  = 64'd1 << 30;
            for (int i = 0; i < 7; i++) begin
                den = dv[i] << 30;
                q = (x2 * t + (den >> 1)) / den;
                t = (q >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - q;
            end
            s = (x * t + (64'd1 << 29)) >> 30;
            if (s > (64'd1 << 30)) s = 64'd1 << 30;
            sine_q30[k] = int'(s);
        end
    endfunction

    function automatic longint round_shift(longint x, int s);
        longint y;
        y = x + (64'sd1 <<< (s - 1));
        return y >>> s;
    endfunction

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic longint sine_at(int j);
        int q, r;
        j = j % MAX_POINTS;
        q = (j / QUARTER) & 3;
        r = j % QUARTER;
        case (q)
            0: return sine_q30[r];
            1: return sine_q30[QUARTER - r];
            2: return -longint'(sine_q30[r]);
            default: return -longint'(sine_q30[QUARTER - r]);
        endcase
    endfunction

    function automatic void rotor(int j, bit inv, output longint wr, output longint wi);
        wr = sine_at(j + QUARTER);
        wi = inv ? -sine_at(j) : sine_at(j);
    endfunction

    function automatic void complex_fft(int nn, int lg, bit inv);
        int j, t0, t1, step;
        longint wr, wi, dr, di, tr, ti, ar, ai;
        for (int i = 0; i < nn; i++) begin
            j = 0;
            for (int b = 0; b < lg; b++)
                if (i & (1 << b)) j |= 1 << (lg - 1 - b);
            if (j > i) begin
                t0 = mem_words[2*i];
                t1 = mem_words[2*i+1];
                mem_words[2*i]   = mem_words[2*j];
                mem_words[2*i+1] = mem_words[2*j+1];
                mem_words[2*j]   = t0;
                mem_words[2*j+1] = t1;
            end
        end
        for (int len = 1; len < nn; len <<= 1) begin
            step = MAX_POINTS / (2 * len);
            for (int m = 0; m < len; m++) begin
                rotor(m * step, inv, wr, wi);
                for (int i = m; i < nn; i += 2 * len) begin
                    j  = i + len;
                    dr = mem_words[2*j];
                    di = mem_words[2*j+1];
                    tr = round_shift(wr * dr - wi * di, 30);
                    ti = round_shift(wr * di + wi * dr, 30);
                    ar = mem_words[2*i];
                    ai = mem_words[2*i+1];
                    mem_words[2*j]   = clip32(ar - tr);
                    mem_words[2*j+1] = clip32(ai - ti);
                    mem_words[2*i]   = clip32(ar + tr);
                    mem_words[2*i+1] = clip32(ai + ti);
                end
            end
        end
    endfunction

    function automatic void split_pass(int n, bit inv);
        int a, b, c, e, step;
        longint s1, s2, s3, s4, p, q, wr, wi, u, v;
        step = MAX_POINTS / n;
        for (int k = 1; k < n / 4; k++) begin
            a = 2 * k; b = a + 1; c = n - 2 * k; e = c + 1;
            s1 = longint'(mem_words[a]) + mem_words[c];
            s2 = longint'(mem_words[b]) - mem_words[e];
            s3 = longint'(mem_words[b]) + mem_words[e];
            s4 = longint'(mem_words[a]) - mem_words[c];
            p = inv ? -s3 : s3;
            q = inv ? s4 : -s4;
            rotor(k * step, inv, wr, wi);
            u = round_shift(wr * p - wi * q, 30);
            v = round_shift(wr * q + wi * p, 30);
            mem_words[a] = clip32(round_shift(s1 + u, 1));
            mem_words[b] = clip32(round_shift(s2 + v, 1));
            mem_words[c] = clip32(round_shift(s1 - u, 1));
            mem_words[e] = clip32(round_shift(-s2 + v, 1));
        end
    endfunction

    function automatic int points();
        int lg;
        lg = cur_lg < LG_MIN ? LG_MIN : (cur_lg > LG_MAX ? LG_MAX : cur_lg);
        return 1 << lg;
    endfunction

    function automatic void transform_words();
        int n, lg;
        longint x0, x1;
        n = points();
        lg = $clog2(n);
        sat_seen = 0;
        if (!cur_inv) begin
            complex_fft(n / 2, lg - 1, 0);
            split_pass(n, 0);
            x0 = mem_words[0]; x1 = mem_words[1];
            mem_words[0] = clip32(x0 + x1);
            mem_words[1] = clip32(x0 - x1);
        end else begin
            split_pass(n, 1);
            x0 = mem_words[0]; x1 = mem_words[1];
            mem_words[0] = clip32(round_shift(x0 + x1, 1));
            mem_words[1] = clip32(round_shift(x0 - x1, 1));
            complex_fft(n / 2, lg - 1, 1);
        end
    endfunction

    function automatic void predict_word(logic [1:0] k, int idx, int val);
        t_word_result r;
        case (k)
            KIND_LOAD: begin
                mem_words[idx] = val;
                written[idx] = 1;
            end
            KIND_RUN: begin
                transform_words();
                r.value = 0; r.is_status = 1; r.ovf = sat_seen;
                pending_words.push_back(r);
            end
            KIND_READ: begin
                r.value = mem_words[idx]; r.is_status = 0; r.ovf = sat_seen;
                pending_words.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge clk) begin
        t_word_result r;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_words.size() == 0) begin
                failures++;
                if (mismatches++ < 10) $display("unexpected word %h", value_res);
            end else begin
                r = pending_words.pop_front();
                if (value_res !== r.value || is_status !== r.is_status || ovf_out !== r.ovf) begin
                    failures++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp %h/%b/%b got %h/%b/%b", r.value,
                                 r.is_status, r.ovf, value_res, is_status, ovf_out);
                end
            end
        end
    end

    // receiver stall
    initial begin
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 26);
            end
        end
    end

    task automatic send_word(logic [1:0] k, int idx, int val);
        if (!no_idle && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        index    <= idx[ADDR_W-1:0];
        value    <= val;
        do @(posedge clk); while (in_stall);
        predict_word(k, idx, val);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic ri, logic [3:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (ri == REG_SIZE_LOG2) cur_lg = d;
        else cur_inv = d[0];
    endtask

    function automatic int rand_word();
        case ($urandom_range(7))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return int'($urandom_range(2097151)) - 1048576;
        endcase
    endfunction

    task automatic fill_points();
        for (int i = 0; i < points(); i++)
            if (!written[i]) send_word(KIND_LOAD, i, rand_word());
    endtask

    task automatic read_points(int cnt);
        for (int i = 0; i < cnt; i++) send_word(KIND_READ, $urandom_range(points() - 1), 0);
    endtask

    task automatic test_directed();
        write_reg(REG_INVERSE, 4'd0);
        write_reg(REG_SIZE_LOG2, 4'd2);
        send_word(KIND_LOAD, 0, 32'sh7fffffff);
        send_word(KIND_LOAD, 1, 32'sh80000000);
        send_word(KIND_LOAD, 2, 32'sh7fffffff);
        send_word(KIND_LOAD, 3, -1);
        send_word(KIND_LOAD, 1023, 32'sh5a5aa5a5);
        send_word(KIND_LOAD, 700, 0);
        for (int i = 0; i < 4; i++) send_word(KIND_READ, i, 0);
        send_word(KIND_NONE, 5, 32'sh12345678);
        send_word(KIND_RUN, 0, 0);
        for (int i = 0; i < 4; i++) send_word(KIND_READ, i, 0);
        send_word(KIND_READ, 1023, 0);
        send_word(KIND_READ, 700, 0);
        send_word(KIND_RUN, 0, 0);
        send_word(KIND_READ, 0, 0);
    endtask

    task automatic test_config_sweep();
        int lgs [8] = '{0, 1, 3, 4, 8, 5, 7, 2};
        for (int s = 0; s < 8; s++) begin
            write_reg(REG_SIZE_LOG2, 4'(lgs[s]));
            write_reg(REG_INVERSE, {3'($urandom_range(7)), s[0]});
            fill_points();
            send_word(KIND_RUN, 0, 0);
            read_points(8);
        end
    endtask

    task automatic test_random();
        int r, idx;
        for (int chunk = 0; chunk < 6; chunk++) begin
            write_reg(REG_SIZE_LOG2, 4'($urandom_range(6, 2)));
            write_reg(REG_INVERSE, 4'($urandom_range(15)));
            no_idle = (chunk == 2);
            for (int i = 0; i < 60; i++) begin
                r = $urandom_range(99);
                if (r < 40) begin
                    idx = ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                   : $urandom_range(points() - 1);
                    send_word(KIND_LOAD, idx, rand_word());
                end else if (r < 85) begin
                    do idx = $urandom_range(1023); while (!written[idx]);
                    if ($urandom_range(3) != 0 && written[idx % points()]) idx = idx % points();
                    send_word(KIND_READ, idx, 0);
                end else if (r < 95) begin
                    fill_points();
                    send_word(KIND_RUN, $urandom_range(1023), $urandom());
                end else begin
                    send_word(KIND_NONE, $urandom_range(1023), $urandom());
                end
            end
            no_idle = 0;
        end
    endtask

    task automatic test_pressure();
        drain();
        hold_cycles = 300;
        read_points(40);
        drain();
        send_word(KIND_RUN, 0, 0);
        read_points(10);
    endtask

    initial begin
        build_sines();
        for (int i = 0; i < MAX_POINTS; i++) begin
            mem_words[i] = 0;
            written[i] = 0;
        end
        sat_seen = 0; cur_inv = 0; cur_lg = 10;
        mismatches = 0; failures = 0; no_idle = 0; hold_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random();
        test_pressure();
        drain();
        if (failures == 0 && pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
